// ----- src/peis_pkg.sv -----
// Package for the particle Euler integrate step unit: payload types, register
// indexes, reset values and shared fixed point helpers. No dependencies.
`default_nettype none
package peis_pkg;

    localparam int unsigned CfgWidth      = 32;
    localparam int unsigned CfgIdxWidth   = 2;
    localparam int unsigned MaxParticles  = 65536;
    localparam int unsigned IdxWidth      = 16;
    localparam int unsigned SqrtSteps     = 32;
    localparam int unsigned DivSteps      = 32;

    localparam logic [CfgIdxWidth-1:0] RegTimeStep     = 2'd0;
    localparam logic [CfgIdxWidth-1:0] RegInverseScale = 2'd1;
    localparam logic [CfgIdxWidth-1:0] RegForceLimit   = 2'd2;
    localparam logic [CfgIdxWidth-1:0] RegGravityZ     = 2'd3;

    localparam logic [30:0] ResetTimeStep     = 31'd66;
    localparam logic [30:0] ResetInverseScale = 31'd65536;
    localparam logic [30:0] ResetForceLimit   = 31'd39321600;
    localparam logic signed [31:0] ResetGravityZ = -32'sd642253;

    typedef struct packed {
        logic [15:0]        original_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] frc_x;
        logic signed [31:0] frc_y;
        logic signed [31:0] frc_z;
        logic signed [31:0] dens;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        out_index;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_dens;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_z;
        logic signed [31:0] out_frc_x;
        logic signed [31:0] out_frc_y;
        logic signed [31:0] out_frc_z;
    } t_out_item;

    // saturate a 34 bit signed value to the Q16.16 range
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Q16.16 product of a signed 32 bit value and an unsigned 31 bit value,
    // truncated toward zero and saturated
    function automatic logic signed [31:0] qmul_su(input logic signed [31:0] a,
                                                  input logic [30:0] b);
        logic [31:0] ma;
        logic [62:0] pr;
        logic [46:0] sh;
        logic        big;
        ma  = a[31] ? 32'(-a) : 32'(a);
        pr  = 63'(ma) * 63'(b);
        sh  = pr[62:16];
        big = |sh[46:31];
        if (!a[31]) begin
            return big ? 32'sh7FFF_FFFF : 32'(sh[30:0]);
        end
        if (big) return 32'sh8000_0000;
        return 32'(-$signed({1'b0, sh[30:0]}));
    endfunction

endpackage
`default_nettype wire

// ----- src/particle_euler_integrate_step_unit.sv -----
// Top level of the particle Euler integrate step unit: configuration
// registers, gravity, force clamp pipeline and the Euler update stages.
// Depends on peis_pkg and peis_clamp.
//
//   channel   | strobe          | payload       | direction
//   ----------+-----------------+---------------+----------
//   item in   | i_start/o_busy  | i_item        | in
//   result    | o_done          | o_result      | out
//   config    | i_cfg_we        | i_cfg_idx/dat | in
//
// One item enters per cycle; o_busy is tied low since the pipeline never
// stalls. Its stages in order: gravity stage, square and sum stages, 32 root
// stages, compare and scale stages, 32 divide stages, then six update stages.
// The square root and the divide set the depth, one result bit per stage.
// Reset clears valid bits and loads register defaults; payload is not reset.
`default_nettype none
module particle_euler_integrate_step_unit #(
    parameter int unsigned MAX_PARTICLES = peis_pkg::MaxParticles
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire peis_pkg::t_in_item                  i_item,
    output logic                                     o_done,
    output peis_pkg::t_out_item                      o_result,
    input  wire logic                                i_cfg_we,
    input  wire logic [peis_pkg::CfgIdxWidth-1:0]    i_cfg_idx,
    input  wire logic [peis_pkg::CfgWidth-1:0]       i_cfg_dat
);
    import peis_pkg::*;

    logic [30:0]        r_time_step;
    logic [30:0]        r_inv_scale;
    logic [30:0]        r_force_limit;
    logic signed [31:0] r_gravity_z;

    // reduce the index modulo MAX_PARTICLES, three compare and subtract
    // steps per update stage, from the largest shifted modulus down
    function automatic logic [15:0] mod_part(input logic [15:0] x,
                                             input int unsigned s);
        logic [40:0] r;
        logic [40:0] d;
        r = 41'(x);
        for (int j = 0; j < 3; j++) begin
            d = 41'(MAX_PARTICLES) << (17 - 3 * s - j);
            if (r >= d) r = r - d;
        end
        return r[15:0];
    endfunction

    // no wait states: accept whenever asked
    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step   <= ResetTimeStep;
            r_inv_scale   <= ResetInverseScale;
            r_force_limit <= ResetForceLimit;
            r_gravity_z   <= ResetGravityZ;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegTimeStep:     r_time_step   <= i_cfg_dat[30:0];
                RegInverseScale: r_inv_scale   <= i_cfg_dat[30:0];
                RegForceLimit:   r_force_limit <= i_cfg_dat[30:0];
                RegGravityZ:     r_gravity_z   <= $signed(i_cfg_dat);
                default: ;
            endcase
        end
    end

    // stage 0: add gravity to force z
    logic               r_v0;
    t_in_item           r_it0;
    logic signed [31:0] r_fz0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else          r_v0 <= i_start && !o_busy;
        r_it0 <= i_item;
        r_fz0 <= sat34(34'(i_item.frc_z) + 34'(r_gravity_z));
    end

    logic               c_valid;
    logic signed [31:0] c_fx, c_fy, c_fz;
    t_in_item           c_item;

    peis_clamp u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_limit (r_force_limit),
        .i_fx    (r_it0.frc_x),
        .i_fy    (r_it0.frc_y),
        .i_fz    (r_fz0),
        .i_item  (r_it0),
        .o_valid (c_valid),
        .o_fx    (c_fx),
        .o_fy    (c_fy),
        .o_fz    (c_fz),
        .o_item  (c_item)
    );

    // update stages: dt*f, v+, dt*v, *inv, p+, *inv; at most one product per stage
    logic               r_vu [6];
    t_in_item           r_iu [6];
    logic [15:0]        r_ix [6];
    logic signed [31:0] r_f  [6][3];
    logic signed [31:0] r_a  [6][3];
    logic signed [31:0] r_nv [6][3];
    logic signed [31:0] c_f [3];
    logic signed [31:0] c_v [3];
    logic signed [31:0] c_p [3];

    always_comb begin
        c_f[0] = c_fx;           c_f[1] = c_fy;           c_f[2] = c_fz;
        c_v[0] = c_item.vel_x;   c_v[1] = c_item.vel_y;   c_v[2] = c_item.vel_z;
        c_p[0] = r_iu[3].pos_x;  c_p[1] = r_iu[3].pos_y;  c_p[2] = r_iu[3].pos_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 6; s++) r_vu[s] <= 1'b0;
        end else begin
            r_vu[0] <= c_valid;
            for (int s = 1; s < 6; s++) r_vu[s] <= r_vu[s-1];
        end
        r_iu[0] <= c_item;
        for (int s = 1; s < 6; s++) r_iu[s] <= r_iu[s-1];
        r_ix[0] <= mod_part(c_item.original_index, 0);
        for (int s = 1; s < 6; s++) r_ix[s] <= mod_part(r_ix[s-1], s);
        for (int k = 0; k < 3; k++) begin
            r_f[0][k] <= c_f[k];
            for (int s = 1; s < 6; s++) r_f[s][k] <= r_f[s-1][k];
            for (int s = 2; s < 6; s++) r_nv[s][k] <= r_nv[s-1][k];
            r_a[0][k]  <= qmul_su(c_f[k], r_time_step);
            r_nv[0][k] <= c_v[k];
            r_nv[1][k] <= sat34(34'(r_nv[0][k]) + 34'(r_a[0][k]));
            r_a[1][k]  <= r_a[0][k];
            r_a[2][k]  <= qmul_su(r_nv[1][k], r_time_step);
            r_a[3][k]  <= qmul_su(r_a[2][k], r_inv_scale);
            r_a[4][k]  <= sat34(34'(c_p[k]) + 34'(r_a[3][k]));
            r_a[5][k]  <= qmul_su(r_a[4][k], r_inv_scale);
        end
    end

    assign o_done = r_vu[5];
    always_comb begin
        o_result.out_index = r_ix[5];
        o_result.out_pos_x = r_a[5][0];
        o_result.out_pos_y = r_a[5][1];
        o_result.out_pos_z = r_a[5][2];
        o_result.out_dens  = r_iu[5].dens;
        o_result.out_vel_x = r_nv[5][0];
        o_result.out_vel_y = r_nv[5][1];
        o_result.out_vel_z = r_nv[5][2];
        o_result.out_frc_x = r_f[5][0];
        o_result.out_frc_y = r_f[5][1];
        o_result.out_frc_z = r_f[5][2];
    end

`ifndef SYNTH
    a_busy_low: assert property (@(posedge i_clk) o_busy == 1'b0)
        else $error("busy raised");
    a_done_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result after reset");
    a_vel_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vu[4] |=> o_result.out_vel_x == $past(r_nv[4][0]))
        else $error("velocity lost in tail");
`endif

endmodule
`default_nettype wire

// ----- src/peis_clamp.sv -----
// Force clamp pipeline: squared length, bit serial square root stages and
// restoring divide stages, one item per cycle. Depends on peis_pkg.
`default_nettype none
module peis_clamp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [30:0]         i_limit,
    input  wire logic signed [31:0]  i_fx,
    input  wire logic signed [31:0]  i_fy,
    input  wire logic signed [31:0]  i_fz,
    input  wire peis_pkg::t_in_item  i_item,
    output logic                     o_valid,
    output logic signed [31:0]       o_fx,
    output logic signed [31:0]       o_fy,
    output logic signed [31:0]       o_fz,
    output peis_pkg::t_in_item       o_item
);
    import peis_pkg::*;

    localparam int unsigned Nq = SqrtSteps;
    localparam int unsigned Nd = DivSteps;

    typedef struct packed {
        logic [30:0]        limit;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        t_in_item           item;
    } t_ctx;

    // stage A: squares (three 32x32 products, each registered)
    logic         r_va;
    t_ctx         r_ca;
    logic [63:0]  r_sq [3];
    // stage B: sum
    logic         r_vb;
    t_ctx         r_cb;
    logic [65:0]  r_sum;
    // square root stages, one result bit per stage
    logic         r_vq [Nq+1];
    t_ctx         r_cq [Nq+1];
    logic [65:0]  r_rem [Nq+1];
    logic [33:0]  r_root [Nq+1];
    // compare stage
    logic         r_vc;
    t_ctx         r_cc;
    logic         r_clamp;
    logic [31:0]  r_len;
    // multiply stage: magnitude times limit
    logic         r_vm;
    t_ctx         r_cm;
    logic         r_cl_m;
    logic [31:0]  r_len_m;
    logic [62:0]  r_num [3];
    // divide stages, one quotient bit per stage
    logic         r_vd [Nd+1];
    t_ctx         r_cd [Nd+1];
    logic         r_cl_d [Nd+1];
    logic [31:0]  r_len_d [Nd+1];
    logic [62:0]  r_dn [Nd+1][3];
    logic [31:0]  r_dr [Nd+1][3];

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vm <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vq[Nq];
            r_vm <= r_vc;
        end
        r_ca.limit <= i_limit;
        r_ca.fx    <= i_fx;
        r_ca.fy    <= i_fy;
        r_ca.fz    <= i_fz;
        r_ca.item  <= i_item;
        r_sq[0]    <= 64'(mag32(i_fx)) * 64'(mag32(i_fx));
        r_sq[1]    <= 64'(mag32(i_fy)) * 64'(mag32(i_fy));
        r_sq[2]    <= 64'(mag32(i_fz)) * 64'(mag32(i_fz));
        r_cb       <= r_ca;
        r_sum      <= 66'(r_sq[0]) + 66'(r_sq[1]) + 66'(r_sq[2]);
        r_cc       <= r_cq[Nq];
        r_clamp    <= r_root[Nq] > 34'(r_cq[Nq].limit);
        r_len      <= r_root[Nq][31:0];
        r_cm       <= r_cc;
        r_cl_m     <= r_clamp;
        r_len_m    <= r_len;
        r_num[0]   <= 63'(mag32(r_cc.fx)) * 63'(r_cc.limit);
        r_num[1]   <= 63'(mag32(r_cc.fy)) * 63'(r_cc.limit);
        r_num[2]   <= 63'(mag32(r_cc.fz)) * 63'(r_cc.limit);
    end

    // square root entry
    always_comb begin
        r_vq[0]   = r_vb;
        r_cq[0]   = r_cb;
        r_rem[0]  = r_sum;
        r_root[0] = '0;
    end

    for (genvar s = 0; s < Nq; s++) begin : g_sqrt
        logic [65:0] n_rem;
        logic [33:0] n_root;
        logic [35:0] trial;
        logic [35:0] pair;
        always_comb begin
            // bring down two bits of the radicand, from the top
            pair  = {r_root[s], 2'b00} | 36'd1;
            trial = 36'(r_rem[s] >> (2 * (Nq - 1 - s)));
            n_rem  = r_rem[s];
            n_root = {r_root[s][32:0], 1'b0};
            if (trial >= pair) begin
                n_rem  = r_rem[s] - (66'(pair) << (2 * (Nq - 1 - s)));
                n_root = {r_root[s][32:0], 1'b1};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vq[s+1] <= 1'b0;
            else          r_vq[s+1] <= r_vq[s];
            r_cq[s+1]   <= r_cq[s];
            r_rem[s+1]  <= n_rem;
            r_root[s+1] <= n_root;
        end
    end

    always_comb begin
        r_vd[0]    = r_vm;
        r_cd[0]    = r_cm;
        r_cl_d[0]  = r_cl_m;
        r_len_d[0] = r_len_m;
        for (int k = 0; k < 3; k++) begin
            r_dn[0][k] = r_num[k];
            r_dr[0][k] = '0;
        end
    end

    // quotient < 2^32 because magnitude <= len when clamping
    for (genvar s = 0; s < Nd; s++) begin : g_div
        logic [62:0] n_dn [3];
        logic [31:0] n_dr [3];
        logic [32:0] part [3];
        always_comb begin
            for (int k = 0; k < 3; k++) begin
                part[k] = 33'(r_dn[s][k] >> (Nd - 1 - s));
                n_dn[k] = r_dn[s][k];
                n_dr[k] = {r_dr[s][k][30:0], 1'b0};
                if (part[k] >= 33'(r_len_d[s])) begin
                    n_dn[k] = r_dn[s][k] - (63'(r_len_d[s]) << (Nd - 1 - s));
                    n_dr[k] = {r_dr[s][k][30:0], 1'b1};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vd[s+1] <= 1'b0;
            else          r_vd[s+1] <= r_vd[s];
            r_cd[s+1]    <= r_cd[s];
            r_cl_d[s+1]  <= r_cl_d[s];
            r_len_d[s+1] <= r_len_d[s];
            for (int k = 0; k < 3; k++) begin
                r_dn[s+1][k] <= n_dn[k];
                r_dr[s+1][k] <= n_dr[k];
            end
        end
    end

    assign o_valid = r_vd[Nd];
    assign o_item  = r_cd[Nd].item;
    assign o_fx = !r_cl_d[Nd] ? r_cd[Nd].fx :
        (r_cd[Nd].fx[31] ? 32'(-$signed(r_dr[Nd][0])) : $signed(r_dr[Nd][0]));
    assign o_fy = !r_cl_d[Nd] ? r_cd[Nd].fy :
        (r_cd[Nd].fy[31] ? 32'(-$signed(r_dr[Nd][1])) : $signed(r_dr[Nd][1]));
    assign o_fz = !r_cl_d[Nd] ? r_cd[Nd].fz :
        (r_cd[Nd].fz[31] ? 32'(-$signed(r_dr[Nd][2])) : $signed(r_dr[Nd][2]));

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for particle_euler_integrate_step_unit: directed and
// random particles under several register settings, checked against a
// behavioral Euler step predictor. Depends on peis_pkg and the unit's RTL.
`timescale 1ns / 100ps

import peis_pkg::*;

// Holds the register copy, predicts each particle update and checks results.
class particle_step_board;
    longint        time_step;
    longint        inv_scale;
    longint        force_limit;
    longint        gravity_z;
    t_out_item     pending[$];
    int unsigned   mismatches;

    function new();
        time_step   = ResetTimeStep;
        inv_scale   = ResetInverseScale;
        force_limit = ResetForceLimit;
        gravity_z   = ResetGravityZ;
        mismatches  = 0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [31:0] dat);
        case (idx)
            RegTimeStep:     time_step   = dat[30:0];
            RegInverseScale: inv_scale   = dat[30:0];
            RegForceLimit:   force_limit = dat[30:0];
            RegGravityZ:     gravity_z   = longint'($signed(dat));
            default: ;
        endcase
    endfunction

    function longint clip(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint unsigned magn(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    // Q16.16 product: truncate toward zero, then saturate
    function longint qprod(longint a, longint b);
        longint unsigned m;
        m = (magn(a) * magn(b)) >> 16;
        return clip(((a < 0) != (b < 0)) ? -longint'(m) : longint'(m));
    endfunction

    function void note_transfer(t_in_item it);
        longint        p[3], v[3], f[3], np[3], stp;
        longint unsigned sum, len, rem, bitv;
        t_out_item     r;
        p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
        v = '{longint'(it.vel_x), longint'(it.vel_y), longint'(it.vel_z)};
        f = '{longint'(it.frc_x), longint'(it.frc_y), longint'(it.frc_z)};
        f[2] = clip(f[2] + gravity_z);
        sum = 0;
        for (int k = 0; k < 3; k++) sum += magn(f[k]) * magn(f[k]);
        // bitwise integer square root
        rem = sum;
        len = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= len + bitv) begin
                rem -= len + bitv;
                len = (len >> 1) + bitv;
            end else begin
                len >>= 1;
            end
            bitv >>= 2;
        end
        if (len > force_limit) begin
            for (int k = 0; k < 3; k++) begin
                stp = longint'((magn(f[k]) * longint'(force_limit)) / len);
                f[k] = f[k] < 0 ? -stp : stp;
            end
        end
        for (int k = 0; k < 3; k++) begin
            v[k]  = clip(v[k] + qprod(time_step, f[k]));
            stp   = qprod(qprod(time_step, v[k]), inv_scale);
            np[k] = qprod(clip(p[k] + stp), inv_scale);
        end
        r.out_index = it.original_index % MaxParticles;
        r.out_pos_x = np[0][31:0];
        r.out_pos_y = np[1][31:0];
        r.out_pos_z = np[2][31:0];
        r.out_dens  = it.dens;
        r.out_vel_x = v[0][31:0];
        r.out_vel_y = v[1][31:0];
        r.out_vel_z = v[2][31:0];
        r.out_frc_x = f[0][31:0];
        r.out_frc_y = f[1][31:0];
        r.out_frc_z = f[2][31:0];
        pending.push_back(r);
    endfunction

    function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            if (mismatches < 10)
                $display("mismatch %s: expected %h actual %h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    function void check_result(t_out_item got);
        t_out_item e;
        if (pending.size() == 0) begin
            if (mismatches < 10) $display("result with none expected: %p", got);
            mismatches++;
            return;
        end
        e = pending.pop_front();
        field("out_index", 32'(e.out_index), 32'(got.out_index));
        field("out_pos_x", e.out_pos_x, got.out_pos_x);
        field("out_pos_y", e.out_pos_y, got.out_pos_y);
        field("out_pos_z", e.out_pos_z, got.out_pos_z);
        field("out_dens",  e.out_dens,  got.out_dens);
        field("out_vel_x", e.out_vel_x, got.out_vel_x);
        field("out_vel_y", e.out_vel_y, got.out_vel_y);
        field("out_vel_z", e.out_vel_z, got.out_vel_z);
        field("out_frc_x", e.out_frc_x, got.out_frc_x);
        field("out_frc_y", e.out_frc_y, got.out_frc_y);
        field("out_frc_z", e.out_frc_z, got.out_frc_z);
    endfunction
endclass

module tb;
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_start;
    logic                    o_busy;
    t_in_item                i_item;
    logic                    o_done;
    t_out_item               o_result;
    logic                    i_cfg_we;
    logic [CfgIdxWidth-1:0]  i_cfg_idx;
    logic [CfgWidth-1:0]     i_cfg_dat;

    particle_step_board board;
    bit no_idle;   // phase flag: when set, send back to back

    particle_euler_integrate_step_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_dat(i_cfg_dat)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous limit: the slowest correct run needs well under this.
    initial begin
        #5_000_000;
        $display("FAIL particle_euler_integrate_step_unit");
        $finish;
    end

    // Sample results mid-cycle, where the strobe and payload are stable.
    always @(negedge i_clk) begin
        if (i_rst_n && o_done) board.check_result(o_result);
    end

    // Mostly short gaps, a few long ones; none in back-to-back phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Issue one transfer; hold start until the block takes it.
    task automatic send(input t_in_item it);
        int gap;
        i_item  <= it;
        i_start <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (!o_busy) break;
        end
        @(posedge i_clk);
        board.note_transfer(it);
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain the pipeline, then write one register while idle.
    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [31:0] dat);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        i_cfg_we  <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_dat <= dat;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        board.write_reg(idx, dat);
    endtask

    // Q16.16 value: mostly physical-scale magnitudes, some full range, some edges.
    function automatic logic [31:0] rand_q();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        if (r < 70) return 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
        if (r < 92) return $urandom();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.original_index = 16'($urandom());
        it.pos_x = rand_q(); it.pos_y = rand_q(); it.pos_z = rand_q();
        it.vel_x = rand_q(); it.vel_y = rand_q(); it.vel_z = rand_q();
        it.frc_x = rand_q(); it.frc_y = rand_q(); it.frc_z = rand_q();
        it.dens  = $urandom();
        return it;
    endfunction

    function automatic t_in_item make_item(logic [15:0] idx, logic [31:0] p,
                                           logic [31:0] v, logic [31:0] fx,
                                           logic [31:0] fy, logic [31:0] fz);
        t_in_item it;
        it.original_index = idx;
        it.pos_x = p;  it.pos_y = -p; it.pos_z = p;
        it.vel_x = v;  it.vel_y = v;  it.vel_z = -v;
        it.frc_x = fx; it.frc_y = fy; it.frc_z = fz;
        it.dens  = p ^ 32'hA5A5_5A5A;
        return it;
    endfunction

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send(rand_item());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        board     = new();
        no_idle   = 1'b0;
        i_rst_n   = 1'b0;
        i_start   = 1'b0;
        i_item    = '0;
        i_cfg_we  = 1'b0;
        i_cfg_idx = RegTimeStep;
        i_cfg_dat = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers, zero and extreme fields, clamp boundary.
        send(make_item(16'h0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
        send(make_item(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send(make_item(16'h8000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        // force exactly at the 600.0 limit after gravity: not clamped
        send(make_item(16'h0001, 32'h0001_0000, 32'h0002_0000,
                       32'h0, 32'h0, 32'd39321600 + 32'd642253));
        // one LSB over the limit: clamped
        send(make_item(16'h0002, 32'h0001_0000, 32'h0002_0000,
                       32'h0, 32'h0, 32'd39321601 + 32'd642253));
        send(make_item(16'h0003, 32'hFFFF_0000, 32'h0, 32'hFA00_0000,
                       32'h0600_0000, 32'h0));
        // gravity pushes frc_z below the Q16.16 floor
        send(make_item(16'h1234, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0001));

        // Extreme settings: saturate the update path.
        write_reg(RegTimeStep, 32'hFFFF_FFFF);
        write_reg(RegInverseScale, 32'h7FFF_FFFF);
        write_reg(RegGravityZ, 32'h7FFF_FFFF);
        send(make_item(16'h0010, 32'h7FFF_FFFF, 32'h0001_0000, 32'h1, 32'h0, 32'h7FFF_FFFF));
        send(make_item(16'h0011, 32'h8000_0000, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0));
        random_phase(150);

        // Zero force limit clamps any nonzero force; zero step and scale.
        write_reg(RegForceLimit, 32'h8000_0000);
        write_reg(RegTimeStep, 32'h0);
        write_reg(RegInverseScale, 32'h0);
        write_reg(RegGravityZ, 32'h8000_0000);
        send(make_item(16'h0020, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF));
        send(make_item(16'h0021, 32'h0, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0));
        random_phase(150);

        // Largest limit: clamp rarely engages.
        write_reg(RegForceLimit, 32'h7FFF_FFFF);
        write_reg(RegTimeStep, 32'h0000_1000);
        write_reg(RegInverseScale, 32'h0002_0000);
        write_reg(RegGravityZ, 32'hFFF6_0000);
        random_phase(200);

        // Several random settings with ordinary-scale stimulus.
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(RegTimeStep, $urandom_range(0, 32'h0004_0000) | ($urandom() & 32'h8000_0000));
            write_reg(RegInverseScale, $urandom_range(0, 32'h0004_0000));
            write_reg(RegForceLimit, (ph == 3) ? $urandom() : $urandom_range(0, 32'h0400_0000));
            write_reg(RegGravityZ, rand_q());
            random_phase(130);
        end

        // Back to reset-like defaults.
        write_reg(RegTimeStep, 32'd66);
        write_reg(RegInverseScale, 32'd65536);
        write_reg(RegForceLimit, 32'd39321600);
        write_reg(RegGravityZ, 32'hFFF6_3333);
        random_phase(200);

        // Drain, then allow the pipeline latency to flush stray results.
        i_start <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("PASS particle_euler_integrate_step_unit");
        end else begin
            $display("FAIL particle_euler_integrate_step_unit");
        end
        $finish;
    end
endmodule
